@@ rtl/core/crs_pkg.sv @@
// Package for the clip rectangle stack: rectangle and intersection types, operation codes,
// register indexes, reset values and the default depth. No dependencies.
package crs_pkg;

   localparam int MAX_DEPTH_DEF = 16;

   localparam logic [1:0] OP_QUERY = 2'd0;
   localparam logic [1:0] OP_PUSH  = 2'd1;
   localparam logic [1:0] OP_POP   = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [14:0] FRAME_WIDTH_RST  = 15'd640;
   localparam logic [14:0] FRAME_HEIGHT_RST = 15'd480;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0]        w;
      logic [14:0]        h;
   } rect_type;

   typedef struct packed {
      logic        visible;
      rect_type    rect;
      logic [15:0] skip_x;
      logic [15:0] skip_y;
   } isect_type;

endpackage

@@ rtl/core/crs_isect.sv @@
// Intersection of one rectangle with the current clip rectangle.
// Depends on crs_pkg.
module crs_isect (
   input  crs_pkg::rect_type  clip,
   input  crs_pkg::rect_type  rect,
   output crs_pkg::isect_type result
);
   import crs_pkg::*;

   logic signed [16:0] x1;
   logic signed [16:0] y1;
   logic signed [16:0] x2;
   logic signed [16:0] y2;
   logic signed [16:0] rx2;
   logic signed [16:0] ry2;
   logic signed [16:0] cx2;
   logic signed [16:0] cy2;
   logic signed [17:0] dw;
   logic signed [17:0] dh;
   logic signed [16:0] sx;
   logic signed [16:0] sy;
   logic               has_w;
   logic               has_h;

   always_comb begin
      rx2 = {rect.x[15], rect.x} + $signed({2'b00, rect.w});
      ry2 = {rect.y[15], rect.y} + $signed({2'b00, rect.h});
      cx2 = {clip.x[15], clip.x} + $signed({2'b00, clip.w});
      cy2 = {clip.y[15], clip.y} + $signed({2'b00, clip.h});
      x1  = (rect.x > clip.x) ? {rect.x[15], rect.x} : {clip.x[15], clip.x};
      y1  = (rect.y > clip.y) ? {rect.y[15], rect.y} : {clip.y[15], clip.y};
      x2  = (rx2 < cx2) ? rx2 : cx2;
      y2  = (ry2 < cy2) ? ry2 : cy2;
      dw  = {x2[16], x2} - {x1[16], x1};
      dh  = {y2[16], y2} - {y1[16], y1};
      sx  = x1 - {rect.x[15], rect.x};
      sy  = y1 - {rect.y[15], rect.y};
      has_w = (dw > 18'sd0);
      has_h = (dh > 18'sd0);

      // Width and height are clamped at zero; they never exceed the input size.
      result.rect.x   = x1[15:0];
      result.rect.y   = y1[15:0];
      result.rect.w   = has_w ? dw[14:0] : 15'd0;
      result.rect.h   = has_h ? dh[14:0] : 15'd0;
      result.skip_x   = sx[15:0];
      result.skip_y   = sy[15:0];
      result.visible  = (clip.w != 15'd0) && (clip.h != 15'd0) && has_w && has_h;
   end

endmodule

@@ rtl/core/clip_rect_stack_core.sv @@
// Top level of the clip rectangle stack: input register, stack state and
// result register. Depends on crs_pkg and crs_isect.
//
//   channel | dir | handshake               | word
//   req     | in  | req_tvalid/req_tready   | tuser: op; tdata: rect x, y, w, h
//   rsp     | out | rsp_tvalid/rsp_tready   | tuser: visible, overflow; tdata: rect, skips
//   csr     | in  | csr_we                  | frame width / height
//
// One word is accepted per cycle unless the result stalls; results are registered.
// The stack top is held in a register and the entry below it is prefetched
// from the stack memory by a registered read, so pushes and pops sustain one
// word per cycle. Reset empties the stack and restores the frame size.
// A stalled result holds the input register; new words then wait.
module clip_rect_stack_core #(
   parameter int MAX_DEPTH = crs_pkg::MAX_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   // rect_x[15:0], rect_y[31:16], rect_w[46:32], rect_h[61:47], zero[63:62]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // visible[0], overflow[1]
   output logic [1:0]  rsp_tuser,
   // clipped_x[15:0], clipped_y[31:16], clipped_w[46:32], clipped_h[61:47],
   // skip_x[77:62], skip_y[93:78], zero[95:94]
   output logic [95:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [14:0] csr_wdata
);
   import crs_pkg::*;

   localparam int CW = $clog2(MAX_DEPTH + 1);
   localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   logic [14:0]   frame_w_ff;
   logic [14:0]   frame_h_ff;

   logic          in_valid_ff;
   logic [1:0]    in_op_ff;
   rect_type      in_rect_ff;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   rect_type      top_ff;
   rect_type      top_in;
   rect_type      below_ff;
   rect_type      stack_mem [MAX_DEPTH];
   logic [CW-1:0] rd_sub;
   logic [AW-1:0] rd_addr;

   logic          rsp_valid_ff;
   logic          rsp_visible_ff;
   rect_type      rsp_rect_ff;
   logic [15:0]   rsp_skip_x_ff;
   logic [15:0]   rsp_skip_y_ff;
   logic          rsp_ovf_ff;

   rect_type      clip;
   isect_type     isect;
   logic          advance;
   logic          full;
   logic          do_push;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_w_ff <= FRAME_WIDTH_RST;
         frame_h_ff <= FRAME_HEIGHT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_FRAME_WIDTH:  frame_w_ff <= csr_wdata;
            REG_FRAME_HEIGHT: frame_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff     <= req_tuser;
         in_rect_ff.x <= req_tdata[15:0];
         in_rect_ff.y <= req_tdata[31:16];
         in_rect_ff.w <= req_tdata[46:32];
         in_rect_ff.h <= req_tdata[61:47];
      end
   end

   // The frame is the clip while the stack is empty.
   always_comb begin
      if (count_ff == '0) begin
         clip.x = 16'sd0;
         clip.y = 16'sd0;
         clip.w = frame_w_ff;
         clip.h = frame_h_ff;
      end else begin
         clip = top_ff;
      end
   end

   crs_isect u_isect (
      .clip   (clip),
      .rect   (in_rect_ff),
      .result (isect)
   );

   assign full    = (count_ff == CW'(MAX_DEPTH));
   assign do_push = advance && (in_op_ff == OP_PUSH) && !full;

   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      if (advance) begin
         unique case (in_op_ff)
            OP_PUSH: begin
               if (!full) begin
                  count_in = count_ff + CW'(1);
                  top_in   = isect.rect;
               end
            end
            OP_POP: begin
               if (count_ff != '0) begin
                  count_in = count_ff - CW'(1);
                  top_in   = below_ff;
               end
            end
            OP_CLEAR: count_in = '0;
            default: ;
         endcase
      end
   end

   // Prefetch the entry below the next top; it was written earlier whenever two or more entries remain.
   assign rd_sub  = count_in - CW'(2);
   assign rd_addr = rd_sub[AW-1:0];

   always_ff @(posedge clock) begin
      if (do_push) begin
         stack_mem[count_ff[AW-1:0]] <= isect.rect;
      end
      below_ff <= stack_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      top_ff <= top_in;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (in_op_ff == OP_QUERY && isect.visible) begin
            rsp_visible_ff <= 1'b1;
            rsp_rect_ff    <= isect.rect;
            rsp_skip_x_ff  <= isect.skip_x;
            rsp_skip_y_ff  <= isect.skip_y;
         end else begin
            rsp_visible_ff <= 1'b0;
            rsp_rect_ff    <= '0;
            rsp_skip_x_ff  <= '0;
            rsp_skip_y_ff  <= '0;
         end
         rsp_ovf_ff <= (in_op_ff == OP_PUSH) && full;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_ovf_ff, rsp_visible_ff};
   assign rsp_tdata  = {2'b00, rsp_skip_y_ff, rsp_skip_x_ff, rsp_rect_ff.h,
                        rsp_rect_ff.w, rsp_rect_ff.y, rsp_rect_ff.x};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_DEPTH))
      else $error("stack count beyond depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (advance && in_op_ff == OP_CLEAR) |=> (count_ff == '0))
      else $error("clear did not empty the stack");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      do_push |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("push did not grow the stack");

   a_ovf_not_visible: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ovf_ff && rsp_visible_ff))
      else $error("overflow and visible both set");

   a_visible_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_visible_ff) |->
         (rsp_rect_ff.w != 15'd0 && rsp_rect_ff.h != 15'd0))
      else $error("visible result with empty rectangle");
`endif

endmodule
